/* rtl/core/tpuhp_pkg.sv */
// tpuhp_pkg: shared types, widths and constants of the two-plane hit pairing block
// no dependencies; imported by the top level, tpuhp_dist and tpuhp_seq
package tpuhp_pkg;

	localparam int HIT_CAPACITY = 32;
	localparam int COORD_BITS   = 24;
	localparam int MAX_RESULTS  = 32;

	localparam int FIELD_W  = 24;
	localparam int RESOL_W  = 16;
	localparam int LAYER_W  = 4;
	localparam int DIST_W   = 20;
	localparam int LIMIT_W  = 8;
	localparam int CFG_IDX_W = 2;

	localparam int AW    = (HIT_CAPACITY > 1) ? $clog2(HIT_CAPACITY) : 1;
	localparam int CNT_W = $clog2(HIT_CAPACITY + 1);
	localparam int RES_W = $clog2(MAX_RESULTS + 1);

	localparam int COORD_SHIFT = (COORD_BITS < FIELD_W) ? FIELD_W - COORD_BITS : 0;

	localparam int DIFF_W     = 22;
	localparam int DIFF_CLAMP = 1 << (DIFF_W - 1);
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int SUM_W      = SQ_W + 1;
	localparam int WIN_SQ_W   = 2 * DIST_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALIGNED_PLANE = 2'd0,
		REG_DISTANCE_MIN  = 2'd1,
		REG_DISTANCE_MAX  = 2'd2,
		REG_HIT_LIMIT     = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [LAYER_W-1:0] aligned_plane;
		logic [DIST_W-1:0]  distance_min;
		logic [DIST_W-1:0]  distance_max;
		logic [LIMIT_W-1:0] hit_limit;
	} cfg_t;

	typedef struct packed {
		logic [RESOL_W-1:0] res;
		logic [FIELD_W-1:0] z;
		logic [FIELD_W-1:0] y;
		logic [FIELD_W-1:0] x;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic          last;
		entry_t        second;
		entry_t        first;
	} pair_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic          re;
		logic [AW-1:0] raddr;
	} mem_ctl_t;

	typedef struct packed {
		logic          launch;
		logic [AW-1:0] idx;
	} scan_t;

	typedef struct packed {
		logic          active;
		logic          valid;
		logic          hit;
		logic [AW-1:0] idx;
	} dist_stat_t;

	// keep the low COORD_BITS bits and sign-extend them to the field width
	function automatic logic [FIELD_W-1:0] coord_sext(input logic [FIELD_W-1:0] v);
		logic signed [FIELD_W-1:0] t;
		t = $signed(v << COORD_SHIFT);
		return t >>> COORD_SHIFT;
	endfunction

endpackage

/* rtl/core/two_plane_unique_hit_pairing.sv */
// two_plane_unique_hit_pairing: top level, configuration registers and store rams
// depends on tpuhp_pkg, tpuhp_ram, tpuhp_dist and tpuhp_seq
//
// Hits are taken one per clock while busy is low. The hit that carries
// event_last closes the event; unless the event is skipped, busy rises and
// the block walks each stored first-plane hit against every stored
// second-plane hit, one second-plane read per cycle from the store ram while
// a scan pass runs. An event skipped by the hit limit, or with an empty
// store, is not walked and leaves busy low. Results appear on pair_valid for
// one cycle each and must be taken as they come; pair_last marks the final
// pair of the event. Configuration writes are always accepted and belong in
// idle time between events.
module two_plane_unique_hit_pairing (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [tpuhp_pkg::LAYER_W-1:0]       layer_index,
	input  logic signed [tpuhp_pkg::FIELD_W-1:0] hit_x,
	input  logic signed [tpuhp_pkg::FIELD_W-1:0] hit_y,
	input  logic signed [tpuhp_pkg::FIELD_W-1:0] hit_z,
	input  logic [tpuhp_pkg::RESOL_W-1:0]       hit_resolution,
	input  logic                                event_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tpuhp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tpuhp_pkg::DIST_W-1:0]        cfg_data,
	output logic                                pair_valid,
	output logic signed [tpuhp_pkg::FIELD_W-1:0] first_x,
	output logic signed [tpuhp_pkg::FIELD_W-1:0] first_y,
	output logic signed [tpuhp_pkg::FIELD_W-1:0] first_z,
	output logic signed [tpuhp_pkg::FIELD_W-1:0] second_x,
	output logic signed [tpuhp_pkg::FIELD_W-1:0] second_y,
	output logic signed [tpuhp_pkg::FIELD_W-1:0] second_z,
	output logic [tpuhp_pkg::RESOL_W-1:0]       first_resolution,
	output logic [tpuhp_pkg::RESOL_W-1:0]       second_resolution,
	output logic                                pair_last
);
	import tpuhp_pkg::*;

	cfg_t       cfg_q;
	entry_t     wr_entry, first_rd, second_rd;
	mem_ctl_t   first_ctl, second_ctl;
	scan_t      scan;
	dist_stat_t dstat;
	pair_t      out_pair;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.aligned_plane <= '0;
			cfg_q.distance_min  <= '0;
			cfg_q.distance_max  <= DIST_W'(2000);
			cfg_q.hit_limit     <= LIMIT_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				REG_ALIGNED_PLANE: cfg_q.aligned_plane <= cfg_data[LAYER_W-1:0];
				REG_DISTANCE_MIN:  cfg_q.distance_min  <= cfg_data;
				REG_DISTANCE_MAX:  cfg_q.distance_max  <= cfg_data;
				REG_HIT_LIMIT:     cfg_q.hit_limit     <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		wr_entry.x   = coord_sext(hit_x);
		wr_entry.y   = coord_sext(hit_y);
		wr_entry.z   = coord_sext(hit_z);
		wr_entry.res = hit_resolution;
	end

	tpuhp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HIT_CAPACITY)
	) u_first_ram (
		.clk   (clk),
		.we    (first_ctl.we),
		.waddr (first_ctl.waddr),
		.wdata (wr_entry),
		.re    (first_ctl.re),
		.raddr (first_ctl.raddr),
		.rdata (first_rd)
	);

	tpuhp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HIT_CAPACITY)
	) u_second_ram (
		.clk   (clk),
		.we    (second_ctl.we),
		.waddr (second_ctl.waddr),
		.wdata (wr_entry),
		.re    (second_ctl.re),
		.raddr (second_ctl.raddr),
		.rdata (second_rd)
	);

	tpuhp_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.scan     (scan),
		.first_q  (first_rd),
		.second_q (second_rd),
		.stat     (dstat)
	);

	tpuhp_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.event_last  (event_last),
		.layer_index (layer_index),
		.cfg         (cfg_q),
		.first_q     (first_rd),
		.second_q    (second_rd),
		.dstat       (dstat),
		.busy        (busy),
		.first_ctl   (first_ctl),
		.second_ctl  (second_ctl),
		.scan        (scan),
		.out_valid   (pair_valid),
		.out_pair    (out_pair)
	);

	assign first_x           = out_pair.first.x;
	assign first_y           = out_pair.first.y;
	assign first_z           = out_pair.first.z;
	assign second_x          = out_pair.second.x;
	assign second_y          = out_pair.second.y;
	assign second_z          = out_pair.second.z;
	assign first_resolution  = out_pair.first.res;
	assign second_resolution = out_pair.second.res;
	assign pair_last         = out_pair.last;

endmodule

/* rtl/core/tpuhp_ram.sv */
// tpuhp_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
module tpuhp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/tpuhp_dist.sv */
// tpuhp_dist: pipelined transverse distance window test of one hit pair
// depends on tpuhp_pkg; fed by the read ports of both hit stores
module tpuhp_dist (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tpuhp_pkg::cfg_t      cfg,
	input  tpuhp_pkg::scan_t     scan,
	input  tpuhp_pkg::entry_t    first_q,
	input  tpuhp_pkg::entry_t    second_q,
	output tpuhp_pkg::dist_stat_t stat
);
	import tpuhp_pkg::*;

	function automatic logic [DIFF_W-1:0] abs_clamp(input logic [FIELD_W-1:0] a,
			input logic [FIELD_W-1:0] b);
		logic signed [FIELD_W:0] d;
		logic [FIELD_W:0]        m;
		d = $signed({a[FIELD_W-1], a}) - $signed({b[FIELD_W-1], b});
		m = d[FIELD_W] ? (FIELD_W+1)'(-d) : d;
		return (m > (FIELD_W+1)'(DIFF_CLAMP)) ? DIFF_W'(DIFF_CLAMP) : m[DIFF_W-1:0];
	endfunction

	logic [WIN_SQ_W-1:0] lo_sq_q, hi_sq_q;

	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [DIFF_W-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3;
	logic [SUM_W-1:0]  sum_s4;
	logic              hit_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= scan.launch;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// window edges squared; registers are to change only while the block is idle, which the block does not enforce
	always_ff @(posedge clk) begin
		lo_sq_q <= {{DIST_W{1'b0}}, cfg.distance_min} * {{DIST_W{1'b0}}, cfg.distance_min};
		hi_sq_q <= {{DIST_W{1'b0}}, cfg.distance_max} * {{DIST_W{1'b0}}, cfg.distance_max};
		idx_s1  <= scan.idx;
		idx_s2  <= idx_s1;
		dx_s2   <= abs_clamp(first_q.x, second_q.x);
		dy_s2   <= abs_clamp(first_q.y, second_q.y);
		idx_s3  <= idx_s2;
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
		idx_s4  <= idx_s3;
		sum_s4  <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
		idx_s5  <= idx_s4;
		hit_s5  <= (sum_s4 >= SUM_W'(lo_sq_q)) && (sum_s4 <= SUM_W'(hi_sq_q));
	end

	assign stat.active = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
	assign stat.valid  = v_s5;
	assign stat.hit    = hit_s5;
	assign stat.idx    = idx_s5;

endmodule

/* rtl/core/tpuhp_seq.sv */
// tpuhp_seq: hit intake, store counts and end-of-event pairing sequencer
// depends on tpuhp_pkg; drives both store rams and the distance pipeline
module tpuhp_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  event_last,
	input  logic [tpuhp_pkg::LAYER_W-1:0] layer_index,
	input  tpuhp_pkg::cfg_t       cfg,
	input  tpuhp_pkg::entry_t     first_q,
	input  tpuhp_pkg::entry_t     second_q,
	input  tpuhp_pkg::dist_stat_t dstat,
	output logic                  busy,
	output tpuhp_pkg::mem_ctl_t   first_ctl,
	output tpuhp_pkg::mem_ctl_t   second_ctl,
	output tpuhp_pkg::scan_t      scan,
	output logic                  out_valid,
	output tpuhp_pkg::pair_t      out_pair
);
	import tpuhp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_TAKE,
		S_PAIR,
		S_FLUSH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] fc_q, sc_q, i_q, j_q;
	logic [RES_W-1:0] n_q;
	logic [1:0]       hits_q;
	logic [AW-1:0]    take_q;
	logic             pend_valid_q;
	pair_t            pend_q;
	logic             out_valid_q;
	pair_t            out_q;

	logic             accept, to_first, to_second, in_limit;
	logic             first_done, scan_end;
	logic [CNT_W-1:0] fc_n, sc_n;
	logic [RES_W-1:0] n_inc;

	always_comb begin
		accept    = start && (state_q == S_IDLE);
		to_first  = (layer_index == '0) && (fc_q < CNT_W'(HIT_CAPACITY));
		to_second = !to_first
			&& (({1'b0, layer_index} + (LAYER_W+1)'(1)) == {1'b0, cfg.aligned_plane})
			&& (sc_q < CNT_W'(HIT_CAPACITY));

		first_ctl.we     = accept && to_first;
		first_ctl.waddr  = fc_q[AW-1:0];
		first_ctl.re     = (state_q == S_SCAN) && (j_q == '0);
		first_ctl.raddr  = i_q[AW-1:0];
		second_ctl.we    = accept && to_second;
		second_ctl.waddr = sc_q[AW-1:0];
		second_ctl.re    = (state_q == S_SCAN) || (state_q == S_TAKE);
		second_ctl.raddr = (state_q == S_TAKE) ? take_q : j_q[AW-1:0];

		scan.launch = (state_q == S_SCAN);
		scan.idx    = j_q[AW-1:0];

		fc_n     = fc_q + CNT_W'(first_ctl.we);
		sc_n     = sc_q + CNT_W'(second_ctl.we);
		in_limit = ((LIMIT_W+1)'(fc_n) <= {1'b0, cfg.hit_limit})
			&& ((LIMIT_W+1)'(sc_n) <= {1'b0, cfg.hit_limit});

		n_inc      = n_q + RES_W'(1);
		first_done = ((i_q + CNT_W'(1)) == fc_q);
		scan_end   = ((j_q + CNT_W'(1)) == sc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fc_q         <= '0;
			sc_q         <= '0;
			i_q          <= '0;
			j_q          <= '0;
			n_q          <= '0;
			hits_q       <= '0;
			take_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			out_valid_q <= ((state_q == S_PAIR) || (state_q == S_FLUSH)) && pend_valid_q;

			// tally in-window candidates of the current first-plane hit
			if (dstat.valid && dstat.hit) begin
				if (hits_q != 2'd2) begin
					hits_q <= hits_q + 2'd1;
				end
				take_q <= dstat.idx;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						fc_q <= fc_n;
						sc_q <= sc_n;
						if (event_last) begin
							if (in_limit && (fc_n != '0) && (sc_n != '0)) begin
								state_q      <= S_SCAN;
								i_q          <= '0;
								j_q          <= '0;
								n_q          <= '0;
								hits_q       <= '0;
								pend_valid_q <= 1'b0;
							end else begin
								fc_q <= '0;
								sc_q <= '0;
							end
						end
					end
				end
				S_SCAN: begin
					j_q <= j_q + CNT_W'(1);
					if (scan_end) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!dstat.active) begin
						if (hits_q == 2'd1) begin
							state_q <= S_TAKE;
						end else if (first_done) begin
							state_q <= S_FLUSH;
						end else begin
							state_q <= S_SCAN;
							i_q     <= i_q + CNT_W'(1);
							j_q     <= '0;
							hits_q  <= '0;
						end
					end
				end
				S_TAKE: begin
					state_q <= S_PAIR;
				end
				S_PAIR: begin
					// hold each pair back one slot so the last one can be marked
					if (pend_valid_q) begin
						out_q <= pend_q;
					end
					pend_valid_q  <= 1'b1;
					pend_q.first  <= first_q;
					pend_q.second <= second_q;
					pend_q.last   <= 1'b0;
					n_q           <= n_inc;
					if (first_done || (n_inc == RES_W'(MAX_RESULTS))) begin
						state_q <= S_FLUSH;
					end else begin
						state_q <= S_SCAN;
						i_q     <= i_q + CNT_W'(1);
						j_q     <= '0;
						hits_q  <= '0;
					end
				end
				S_FLUSH: begin
					if (pend_valid_q) begin
						out_q <= {1'b1, pend_q.second, pend_q.first};
					end
					pend_valid_q <= 1'b0;
					fc_q         <= '0;
					sc_q         <= '0;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_pair  = out_q;

endmodule

/* rtl/core/tpuhp_checker.sv */
// tpuhp_checker: port-level assertions for the two-plane hit pairing block
// depends on two_plane_unique_hit_pairing ports; attached by bind below
module tpuhp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic event_last,
	input logic pair_valid,
	input logic pair_last
);

	// a hit that does not close the event never stalls intake
	a_plain_hit_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !event_last) |=> !busy)
		else $error("busy after a hit that does not close the event");

	// nothing follows the final pair of an event in the next cycle
	a_quiet_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_valid && pair_last) |=> !pair_valid)
		else $error("pair strobe right after the final pair");

	// the final pair of an event shows once the block is back to idle
	a_last_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_valid && pair_last) |-> !busy)
		else $error("final pair shown while still busy");

	// a pair that is not the final one leaves the walk still running
	a_more_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_valid && !pair_last) |-> busy)
		else $error("non-final pair shown after the walk ended");

endmodule

bind two_plane_unique_hit_pairing tpuhp_checker u_tpuhp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.event_last (event_last),
	.pair_valid (pair_valid),
	.pair_last  (pair_last)
);
